>>> hw/rtl/hosp_pkg.sv
// ----------------------------------------------------------------------------
// hosp_pkg
// shared widths, register indexes and controller state codes for the hall
// odometer speed estimator
// ----------------------------------------------------------------------------
`default_nettype none

package hosp_pkg;

  localparam int unsigned CODE_W   = 3;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SPEED_W  = 21;
  localparam int unsigned ODO_W    = 32;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned MAP_W    = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned SCALE_BITS  = 20;
  localparam logic [SCALE_BITS-1:0] SPEED_SCALE = 20'd1000000;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd19000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HALL_MAP     = 3'd0,
    CFG_TARGET_SPEED = 3'd1,
    CFG_GAIN_P       = 3'd2,
    CFG_GAIN_I       = 3'd3,
    CFG_GAIN_D       = 3'd4,
    CFG_COMMAND_MAX  = 3'd5,
    CFG_COMMAND_MIN  = 3'd6,
    CFG_STALL_TIMEOUT = 3'd7
  } cfg_idx_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_EVAL = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_ERR  = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_UPD  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/hosp_if.sv
// ----------------------------------------------------------------------------
// hosp channel interfaces
// hall event input, result output and configuration write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface hosp_in_if import hosp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   hall_code;
  logic [TIME_W-1:0]   time_us;
  modport source (output valid, hall_code, time_us, input ready);
  modport sink   (input valid, hall_code, time_us, output ready);
endinterface

interface hosp_out_if import hosp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SPEED_W-1:0]  command_speed;
  logic signed [SPEED_W-1:0]  measured_speed;
  logic signed [ODO_W-1:0]    odometer;
  logic                       fault;
  modport source (output valid, command_speed, measured_speed, odometer, fault,
                  input ready);
  modport sink   (input valid, command_speed, measured_speed, odometer, fault,
                  output ready);
endinterface

interface hosp_cfg_if import hosp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hall_odometer_speed_pid_top.sv
// ----------------------------------------------------------------------------
// hall_odometer_speed_pid_top
// hall sector tracker, odometer, bit-serial speed divider and PID command
// ----------------------------------------------------------------------------
// usage:
//   hall_i carries one hall event per transaction (code and microsecond time).
//   result_o carries zero or one result per event: command, measured speed,
//   odometer and fault flag. cfg_i writes one register per transaction and is
//   always ready; write it only while the block is idle.
// sequencing:
//   one event at a time. a sector step runs a restoring divider that makes
//   one quotient bit per cycle, then the PID runs its three products through
//   one shared 16x31 multiplier. zero-gap steps and stall timeouts skip the
//   divider; fault results and events without result skip the divider and PID.
// reset:
//   all state and registers clear, stall timeout loads 19000, no sector seen.
// stall:
//   the result register holds until taken; a finished event waits in its
//   output state, and hall_i.ready stays low until the controller is back in
//   idle.
// ----------------------------------------------------------------------------
`default_nettype none

module hall_odometer_speed_pid_top import hosp_pkg::*; #(
  parameter int unsigned TIME_BITS      = 32,
  parameter int unsigned GAIN_FRAC_BITS = 12
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  hosp_in_if.sink      hall_i,
  hosp_out_if.source   result_o,
  hosp_cfg_if.sink     cfg_i
);

  localparam int unsigned ERR_W  = SPEED_W + 1;
  localparam int unsigned DIFF_W = SPEED_W + 2;
  localparam int unsigned INT_W  = 30;
  localparam int unsigned OPB_W  = 31;
  localparam int unsigned PROD_W = GAIN_W + OPB_W;
  localparam int unsigned ACC_W  = 56;
  localparam int unsigned IUP_W  = 42;
  localparam int unsigned CORR_SHIFT = GAIN_FRAC_BITS + 8;

  // configuration registers
  logic [MAP_W-1:0]          hall_map_q;
  logic signed [SPEED_W-1:0] target_q, cmd_max_q, cmd_min_q;
  logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [TIME_W-1:0]         timeout_q;

  // tracker and controller state
  state_e                    state_q;
  logic [2:0]                prev_sector_q;
  logic                      seen_q;
  logic [TIME_BITS-1:0]      last_time_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic [ODO_W-1:0]          count_q;
  logic signed [SPEED_W-1:0] cmd_q;
  logic signed [ERR_W-1:0]   err_prev_q;
  logic signed [INT_W-1:0]   integ_q;
  logic                      started_q;

  // per event
  logic [CODE_W-1:0]         code_q;
  logic [TIME_BITS-1:0]      now_q;
  logic [TIME_BITS-1:0]      gap_q;
  logic                      neg_q;
  logic                      fault_q;

  // divider
  logic [TIME_BITS:0]        rem_q;
  logic [SCALE_BITS-1:0]     dvd_q;
  logic [SCALE_BITS-1:0]     quo_q;
  logic [4:0]                dcnt_q;

  // pid datapath
  logic signed [ERR_W-1:0]   err_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      prod_sh_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [1:0]                mcnt_q;

  // result register
  logic                      out_valid_q;
  logic signed [SPEED_W-1:0] out_cmd_q, out_speed_q;
  logic [ODO_W-1:0]          out_odo_q;
  logic                      out_fault_q;

  function automatic logic signed [SPEED_W-1:0] clamp_cmd(
    input logic signed [ACC_W-1:0] c,
    input logic signed [SPEED_W-1:0] hi,
    input logic signed [SPEED_W-1:0] lo
  );
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] hi_x;
    logic signed [ACC_W-1:0] lo_x;
    hi_x = ACC_W'(hi);
    lo_x = ACC_W'(lo);
    r = c;
    if (r > hi_x) r = hi_x;
    if (r < lo_x) r = lo_x;
    return r[SPEED_W-1:0];
  endfunction

  // event decode
  logic [2:0]           sector;
  logic                 code_ok;
  logic [TIME_BITS-1:0] gap;
  logic                 fwd, bwd;

  always_comb begin
    case (code_q)
      3'd1:    sector = hall_map_q[2:0];
      3'd2:    sector = hall_map_q[5:3];
      3'd3:    sector = hall_map_q[8:6];
      3'd4:    sector = hall_map_q[11:9];
      3'd5:    sector = hall_map_q[14:12];
      3'd6:    sector = hall_map_q[17:15];
      default: sector = 3'd0;
    endcase
    code_ok = (code_q != 3'd0) && (code_q != 3'd7) && (sector <= 3'd5);
    gap = now_q - last_time_q;
    fwd = (sector == prev_sector_q + 3'd1) || ((sector == 3'd0) && (prev_sector_q == 3'd5));
    bwd = ({1'b0, sector} + 4'd1 == {1'b0, prev_sector_q})
          || ((sector == 3'd5) && (prev_sector_q == 3'd0));
  end

  // divider step
  logic [TIME_BITS:0] trial;
  logic [TIME_BITS:0] trial_sub;
  logic               trial_ge;
  assign trial     = {rem_q[TIME_BITS-1:0], dvd_q[SCALE_BITS-1]};
  assign trial_ge  = trial >= {1'b0, gap_q};
  assign trial_sub = trial - {1'b0, gap_q};

  // shared multiplier
  logic signed [GAIN_W-1:0] mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] mul_p;
  always_comb begin
    case (mcnt_q)
      2'd0: begin
        mul_a = gain_p_q;
        mul_b = OPB_W'(err_q);
      end
      2'd1: begin
        mul_a = gain_d_q;
        mul_b = OPB_W'(diff_q);
      end
      default: begin
        mul_a = gain_i_q;
        mul_b = OPB_W'(integ_q);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic signed [ACC_W-1:0] prod_x;
  assign prod_x = prod_sh_q ? (ACC_W'(prod_q) <<< 8) : ACC_W'(prod_q);

  // end of pid
  logic signed [ACC_W-1:0] corr;
  logic signed [ACC_W-1:0] cmd_raw;
  logic signed [IUP_W-1:0] integ_x;
  logic signed [IUP_W-1:0] err_x;
  logic signed [IUP_W-1:0] integ_sum;
  assign corr      = acc_q >>> CORR_SHIFT;
  assign cmd_raw   = ACC_W'(cmd_q) - corr;
  assign integ_x   = IUP_W'(integ_q);
  assign err_x     = IUP_W'(err_q);
  assign integ_sum = (integ_x <<< 8) - (integ_x <<< 4) - (integ_x <<< 3) - (integ_x <<< 1)
                     + (((err_x <<< 4) + (err_x <<< 3) + (err_x <<< 1)) <<< 8);

  logic signed [ERR_W-1:0] err_now;
  assign err_now = ERR_W'(target_q) - ERR_W'(speed_q);

  logic signed [SPEED_W-1:0] quo_s;
  assign quo_s = SPEED_W'(quo_q);

  logic out_free;
  assign out_free = !out_valid_q || result_o.ready;

  assign hall_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready   = 1'b1;
  assign result_o.valid          = out_valid_q;
  assign result_o.command_speed  = out_cmd_q;
  assign result_o.measured_speed = out_speed_q;
  assign result_o.odometer       = out_odo_q;
  assign result_o.fault          = out_fault_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hall_map_q <= '0;
      target_q   <= '0;
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
      cmd_max_q  <= '0;
      cmd_min_q  <= '0;
      timeout_q  <= TIMEOUT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_HALL_MAP:      hall_map_q <= cfg_i.data[MAP_W-1:0];
        CFG_TARGET_SPEED:  target_q   <= cfg_i.data[SPEED_W-1:0];
        CFG_GAIN_P:        gain_p_q   <= cfg_i.data[GAIN_W-1:0];
        CFG_GAIN_I:        gain_i_q   <= cfg_i.data[GAIN_W-1:0];
        CFG_GAIN_D:        gain_d_q   <= cfg_i.data[GAIN_W-1:0];
        CFG_COMMAND_MAX:   cmd_max_q  <= cfg_i.data[SPEED_W-1:0];
        CFG_COMMAND_MIN:   cmd_min_q  <= cfg_i.data[SPEED_W-1:0];
        CFG_STALL_TIMEOUT: timeout_q  <= cfg_i.data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // controller
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      prev_sector_q <= '0;
      seen_q        <= 1'b0;
      last_time_q   <= '0;
      speed_q       <= '0;
      count_q       <= '0;
      cmd_q         <= '0;
      err_prev_q    <= '0;
      integ_q       <= '0;
      started_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      fault_q       <= 1'b0;
      neg_q         <= 1'b0;
      dcnt_q        <= '0;
      mcnt_q        <= '0;
      code_q        <= '0;
      now_q         <= '0;
      gap_q         <= '0;
      rem_q         <= '0;
      dvd_q         <= '0;
      quo_q         <= '0;
      err_q         <= '0;
      diff_q        <= '0;
      prod_q        <= '0;
      prod_sh_q     <= 1'b0;
      acc_q         <= '0;
      out_cmd_q     <= '0;
      out_speed_q   <= '0;
      out_odo_q     <= '0;
      out_fault_q   <= 1'b0;
    end else begin
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid && cfg_idx_e'(cfg_i.index) == CFG_TARGET_SPEED) begin
        cmd_q <= clamp_cmd(ACC_W'($signed(cfg_i.data[SPEED_W-1:0])), cmd_max_q, cmd_min_q);
      end
      case (state_q)
        ST_IDLE: begin
          if (hall_i.valid) begin
            code_q  <= hall_i.hall_code;
            now_q   <= hall_i.time_us[TIME_BITS-1:0];
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          gap_q <= gap;
          if (!code_ok) begin
            fault_q <= 1'b1;
            state_q <= ST_OUT;
          end else if (!seen_q) begin
            seen_q        <= 1'b1;
            prev_sector_q <= sector;
            last_time_q   <= now_q;
            state_q       <= ST_IDLE;
          end else if (sector == prev_sector_q) begin
            if (TIME_W'(gap) > timeout_q) begin
              fault_q     <= 1'b0;
              speed_q     <= '0;
              last_time_q <= now_q;
              state_q     <= ST_ERR;
            end else begin
              state_q     <= ST_IDLE;
            end
          end else if (fwd || bwd) begin
            fault_q       <= 1'b0;
            prev_sector_q <= sector;
            last_time_q   <= now_q;
            neg_q         <= bwd;
            count_q       <= fwd ? count_q + ODO_W'(1) : count_q - ODO_W'(1);
            if (gap == '0) begin
              speed_q <= bwd ? -SPEED_W'(SPEED_SCALE) : SPEED_W'(SPEED_SCALE);
              state_q <= ST_ERR;
            end else begin
              rem_q   <= '0;
              dvd_q   <= SPEED_SCALE;
              dcnt_q  <= '0;
              state_q <= ST_DIV;
            end
          end else begin
            prev_sector_q <= sector;
            last_time_q   <= now_q;
            fault_q       <= 1'b1;
            state_q       <= ST_OUT;
          end
        end
        ST_DIV: begin
          rem_q  <= trial_ge ? trial_sub : trial;
          quo_q  <= {quo_q[SCALE_BITS-2:0], trial_ge};
          dvd_q  <= {dvd_q[SCALE_BITS-2:0], 1'b0};
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'(SCALE_BITS - 1)) begin
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          if (dcnt_q == 5'(SCALE_BITS)) begin
            speed_q <= neg_q ? -quo_s : quo_s;
            dcnt_q  <= '0;
          end else begin
            err_q   <= err_now;
            diff_q  <= started_q ? DIFF_W'(err_now) - DIFF_W'(err_prev_q) : '0;
            acc_q   <= '0;
            mcnt_q  <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mcnt_q != 2'd0) acc_q <= acc_q + prod_x;
          prod_q    <= mul_p;
          prod_sh_q <= (mcnt_q != 2'd2);
          mcnt_q    <= mcnt_q + 2'd1;
          if (mcnt_q == 2'd3) state_q <= ST_UPD;
        end
        ST_UPD: begin
          cmd_q      <= clamp_cmd(cmd_raw, cmd_max_q, cmd_min_q);
          integ_q    <= INT_W'(integ_sum >>> 8);
          err_prev_q <= err_q;
          started_q  <= 1'b1;
          state_q    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_cmd_q   <= cmd_q;
            out_speed_q <= speed_q;
            out_odo_q   <= count_q;
            out_fault_q <= fault_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
